// ===== rtl/core/hhg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhg_pkg: shared constants and types for the gating rate unit
// Fixed-point defaults, exp() constants, the pow2 polynomial table and the
// register, mode and status codes.
// ----------------------------------------------------------------------------
package hhg_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W     = 2;

  // exp() input window, in whole units
  localparam int unsigned EXP_HI = 22;
  localparam int unsigned EXP_LO = 64;

  // log2(e) in Q2.30
  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;

  // 2^t polynomial, Q30, lowest order first
  localparam int unsigned POLY_LEN = 11;
  localparam logic [31:0] POW2_POLY [POLY_LEN] = '{
    32'd1073741824, 32'd744261118, 32'd257941248, 32'd59597083, 32'd10327387,
    32'd1431680, 32'd165394, 32'd16377, 32'd1419, 32'd109, 32'd8
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_MODE   = 2'd0,
    REG_MIDPOINT    = 2'd1,
    REG_RATE_GAIN   = 2'd2,
    REG_SLOPE_SCALE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_EXP     = 2'd0,
    MODE_EXPLIN  = 2'd1,
    MODE_SIGMOID = 2'd2
  } rate_mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SATURATED  = 2'd1,
    ST_ZERO_SCALE = 2'd2
  } status_e;

endpackage

// ===== rtl/core/hhg_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhg_div_pipe: pipelined restoring divider
// One quotient bit per stage, NW stages, unsigned. A sideband vector rides
// along with each transaction.
// ----------------------------------------------------------------------------
module hhg_div_pipe #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] nq_q   [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic          vin;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign vin     = valid_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign nq_in   = nq_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_q[j]   <= {nq_in[NW-2:0], ge};
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quot_o  = nq_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

// ===== rtl/core/hhg_exp_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhg_exp_pipe: pipelined fixed-point exp()
// Range check, scale by log2(e), split into integer and fraction, ten Horner
// steps of the 2^t polynomial, final shift. Fourteen register stages.
// ----------------------------------------------------------------------------
module hhg_exp_pipe import hhg_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned ZW        = FRAC_BITS + 33,
  parameter int unsigned SW        = 1,
  localparam int unsigned EW       = FRAC_BITS + 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic        [SW-1:0] side_i,
  output logic                 valid_o,
  output logic        [EW-1:0] e_o,
  output logic                 ovf_o,
  output logic        [SW-1:0] side_o
);

  localparam int unsigned CW = FRAC_BITS + 8;   // in-window input width
  localparam int unsigned PW = CW + 32;
  localparam int unsigned NB = CW + 2 - FRAC_BITS;
  localparam int unsigned HS = POLY_LEN - 1;
  localparam logic signed [ZW-1:0] ZHI = ZW'(EXP_HI) << FRAC_BITS;
  localparam logic signed [ZW-1:0] ZLO = ZW'(0) - (ZW'(EXP_LO) << FRAC_BITS);

  typedef struct packed {
    logic                 ovf;
    logic                 und;
    logic signed [NB-1:0] n;
    logic        [SW-1:0] side;
  } carry_t;

  // E0: window check
  logic                 e0_v_q, e0_ovf_q, e0_und_q;
  logic signed [CW-1:0] e0_zc_q;
  logic        [SW-1:0] e0_side_q;
  // E1: times log2(e)
  logic                 e1_v_q, e1_ovf_q, e1_und_q;
  logic signed [PW-1:0] e1_prod_q, e1_prod_d;
  logic        [SW-1:0] e1_side_q;
  // E2: integer / fraction split
  logic                 e2_v_q;
  logic        [29:0]   e2_t_q;
  carry_t               e2_c_q;
  logic signed [CW+1:0] y;
  // Horner steps
  logic                 hv_q   [HS];
  logic        [31:0]   hacc_q [HS];
  logic        [29:0]   ht_q   [HS];
  carry_t               hc_q   [HS];
  // final shift
  logic signed [NB-1:0] sh;
  logic        [NB-1:0] rs;
  logic        [EW-1:0] shifted;
  logic                 ev_q, eovf_q;
  logic        [EW-1:0] e_q;
  logic        [SW-1:0] eside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_v_q <= 1'b0;
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      ev_q   <= 1'b0;
    end else if (en_i) begin
      e0_v_q <= valid_i;
      e1_v_q <= e0_v_q;
      e2_v_q <= e1_v_q;
      ev_q   <= hv_q[HS-1];
    end
  end

  assign e1_prod_d = e0_zc_q * LOG2E_Q30;
  assign y         = e1_prod_q[PW-1:30];   // floor by arithmetic shift

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e0_ovf_q    <= z_i >= ZHI;
      e0_und_q    <= z_i < ZLO;
      e0_zc_q     <= z_i[CW-1:0];
      e0_side_q   <= side_i;
      e1_prod_q   <= e1_prod_d;
      e1_ovf_q    <= e0_ovf_q;
      e1_und_q    <= e0_und_q;
      e1_side_q   <= e0_side_q;
      e2_t_q      <= 30'(y[FRAC_BITS-1:0]) << (30 - FRAC_BITS);
      e2_c_q.n    <= y[CW+1:FRAC_BITS];
      e2_c_q.ovf  <= e1_ovf_q;
      e2_c_q.und  <= e1_und_q;
      e2_c_q.side <= e1_side_q;
    end
  end

  for (genvar j = 0; j < HS; j++) begin : g_horner
    logic        vin;
    logic [31:0] acc_in;
    logic [29:0] t_in;
    carry_t      c_in;
    logic [61:0] hp;

    if (j == 0) begin : g_first
      assign vin    = e2_v_q;
      assign acc_in = POW2_POLY[POLY_LEN-1];
      assign t_in   = e2_t_q;
      assign c_in   = e2_c_q;
    end else begin : g_next
      assign vin    = hv_q[j-1];
      assign acc_in = hacc_q[j-1];
      assign t_in   = ht_q[j-1];
      assign c_in   = hc_q[j-1];
    end

    assign hp = acc_in * t_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hv_q[j] <= 1'b0;
      end else if (en_i) begin
        hv_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hacc_q[j] <= POW2_POLY[HS-1-j] + hp[61:30];
        ht_q[j]   <= t_in;
        hc_q[j]   <= c_in;
      end
    end
  end

  // Q30 result to FRAC_BITS: shift by n + FRAC_BITS - 30
  assign sh = hc_q[HS-1].n + $signed(NB'(FRAC_BITS)) - $signed(NB'(30));
  assign rs = NB'(0) - sh;

  always_comb begin
    if (!sh[NB-1]) begin
      shifted = EW'(hacc_q[HS-1]) << sh[4:0];
    end else if (rs >= NB'(32)) begin
      shifted = '0;
    end else begin
      shifted = EW'(hacc_q[HS-1] >> rs[4:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q     <= (hc_q[HS-1].ovf || hc_q[HS-1].und) ? '0 : shifted;
      eovf_q  <= hc_q[HS-1].ovf;
      eside_q <= hc_q[HS-1].side;
    end
  end

  assign valid_o = ev_q;
  assign e_o     = e_q;
  assign ovf_o   = eovf_q;
  assign side_o  = eside_q;

endmodule

// ===== rtl/core/hhg_sat_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhg_sat_mul: gain times wide operand, scaled and saturation-checked
// Two partial products over two stages; the sum, scale and limit check are
// left combinational for the output register.
// ----------------------------------------------------------------------------
module hhg_sat_mul import hhg_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned SW        = 1,
  localparam int unsigned QW       = FRAC_BITS + 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   ar_i,
  input  logic          neg_i,
  input  logic [QW-1:0] q_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [31:0]   m_o,
  output logic          sat_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned SUMW = FRAC_BITS + 64;

  logic                 m1_v_q, m2_v_q;
  logic [63:0]          m1_pl_q, m2_pl_q;
  logic [FRAC_BITS-1:0] m1_qh_q;
  logic [QW-1:0]        m2_ph_q;
  logic [SW-1:0]        m1_side_q, m2_side_q;
  logic [SUMW-1:0]      sum;
  logic [63:0]          m;
  logic [31:0]          limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else if (en_i) begin
      m1_v_q <= valid_i;
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_pl_q   <= ar_i * q_i[31:0];
      m1_qh_q   <= q_i[QW-1:32];
      m1_side_q <= side_i;
      m2_pl_q   <= m1_pl_q;
      m2_ph_q   <= ar_i * m1_qh_q;
      m2_side_q <= m1_side_q;
    end
  end

  assign sum   = {m2_ph_q, 32'd0} + SUMW'(m2_pl_q);
  assign m     = sum[SUMW-1:FRAC_BITS];
  assign limit = neg_i ? 32'h8000_0000 : 32'h7fff_ffff;

  assign valid_o = m2_v_q;
  assign m_o     = m[31:0];
  assign sat_o   = (|m[63:32]) || (m[31:0] > limit);
  assign side_o  = m2_side_q;

endmodule

// ===== rtl/core/hh_gating_rate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hh_gating_rate_unit: Hodgkin-Huxley gating rate, fully pipelined
// Voltage in, rate (exponential, exponential-linear or sigmoid) out, signed
// fixed point with FRAC_BITS fractional bits (Q16.16 by default).
// ----------------------------------------------------------------------------
// One voltage transaction is accepted every clock while in_ready_o is high,
// and one rate transaction comes out per voltage, in order. The pipeline is
// made up of the two bit-per-stage dividers (32 + FRAC_BITS stages each: the
// voltage scaling and the exponential-linear/sigmoid quotient), a 14-stage
// exp() pipeline and the two-stage gain multiply. The whole pipeline holds
// as one when the output register is full and not taken, unless its last
// stage is empty, so bubbles keep draining and new voltages keep entering
// while a result waits. Configuration registers are read live where used and
// may only be written while no transaction is in flight. status_o reports
// saturation of the rate and a zero slope_scale; an unused rate_mode gives
// zero with status OK.
// ----------------------------------------------------------------------------
module hh_gating_rate_unit import hhg_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  // voltage in
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   voltage_i,
  // rate out
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   rate_value_o,
  output logic [1:0]           status_o
);

  localparam int unsigned AW  = FRAC_BITS + 32;  // |x| in fixed point
  localparam int unsigned ZW  = AW + 1;          // signed exp() argument
  localparam int unsigned EW  = FRAC_BITS + 32;  // exp() result
  localparam int unsigned N2  = FRAC_BITS + 32;  // second divider numerator
  localparam int unsigned D2  = FRAC_BITS + 33;  // second divider denominator
  localparam int unsigned QW  = FRAC_BITS + 32;  // multiply operand
  localparam int unsigned PAW = 2 * FRAC_BITS + 8;
  localparam int unsigned AT  = FRAC_BITS + 7;   // |x| bits that matter when exp(-|x|) != 0
  localparam logic [D2-1:0] ONE = D2'(1) << FRAC_BITS;

  // how the final stage forms the result
  typedef enum logic [1:0] {
    K_ZERO   = 2'd0,
    K_SAT    = 2'd1,
    K_DIRECT = 2'd2,
    K_MUL    = 2'd3
  } res_kind_e;

  typedef struct packed {
    logic [AW-1:0] a;
    logic          xneg;
  } exp_side_t;

  typedef struct packed {
    logic [EW-1:0] e;
    logic          ovf;
    logic [AW-1:0] a;
    logic          xneg;
    logic          azero;
    logic          wz;
  } div_side_t;

  typedef struct packed {
    res_kind_e   kind;
    logic [31:0] mdir;
  } mul_side_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        [1:0]  mode_q;
  logic signed [31:0] mid_q, gain_q, scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_EXP;
      mid_q   <= '0;
      gain_q  <= 32'sd65536;
      scale_q <= 32'sd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RATE_MODE:   mode_q  <= cfg_wdata_i[1:0];
        REG_MIDPOINT:    mid_q   <= cfg_wdata_i;
        REG_RATE_GAIN:   gain_q  <= cfg_wdata_i;
        REG_SLOPE_SCALE: scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic        sneg, rneg, szero, mode_ok;
  logic [31:0] smag, ar;

  assign sneg    = scale_q[31];
  assign rneg    = gain_q[31];
  assign szero   = scale_q == '0;
  assign smag    = sneg ? 32'd0 - scale_q : scale_q;
  assign ar      = rneg ? 32'd0 - gain_q : gain_q;
  assign mode_ok = mode_q inside {MODE_EXP, MODE_EXPLIN, MODE_SIGMOID};

  // --------------------------------------------------------------------------
  // Global advance: hold only when the output is stuck and the last stage
  // has something to hand over.
  // --------------------------------------------------------------------------
  logic out_valid_q, out_free, last_v, adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = out_free || !last_v;
  assign in_ready_o = adv;

  // --------------------------------------------------------------------------
  // S0/S1: capture, v - midpoint, magnitude
  // --------------------------------------------------------------------------
  logic               s0_v_q, s1_v_q;
  logic signed [31:0] s0_volt_q;
  logic signed [32:0] d;
  logic        [31:0] s1_mag_q;
  logic               s1_dneg_q;

  assign d = 33'(s0_volt_q) - 33'(mid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_valid_i;
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_volt_q <= voltage_i;
      s1_mag_q  <= d[32] ? 32'(33'd0 - d) : d[31:0];
      s1_dneg_q <= d[32];
    end
  end

  // --------------------------------------------------------------------------
  // Divider 1: |x| = |d| * 2^F / |scale|
  // --------------------------------------------------------------------------
  logic          dv1_v, dv1_dneg;
  logic [AW-1:0] dv1_a;

  hhg_div_pipe #(
    .NW (AW),
    .DW (32),
    .SW (1)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s1_v_q),
    .num_i   ({s1_mag_q, FRAC_BITS'(0)}),
    .den_i   (smag),
    .side_i  (s1_dneg_q),
    .valid_o (dv1_v),
    .quot_o  (dv1_a),
    .side_o  (dv1_dneg)
  );

  // --------------------------------------------------------------------------
  // X: sign of x and the signed exp() argument for the mode
  // --------------------------------------------------------------------------
  logic                 x_v_q;
  logic signed [ZW-1:0] x_z_q;
  exp_side_t            x_side_q;
  logic                 xneg, zneg;

  assign xneg = (dv1_a != '0) && (dv1_dneg != sneg);
  assign zneg = (mode_q == MODE_EXPLIN) || ((mode_q == MODE_EXP) ? xneg : !xneg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_v_q <= 1'b0;
    end else if (adv) begin
      x_v_q <= dv1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_z_q         <= zneg ? ZW'(0) - ZW'(dv1_a) : ZW'(dv1_a);
      x_side_q.a    <= dv1_a;
      x_side_q.xneg <= xneg;
    end
  end

  // --------------------------------------------------------------------------
  // exp()
  // --------------------------------------------------------------------------
  logic          ex_v, ex_ovf;
  logic [EW-1:0] ex_e;
  exp_side_t     ex_side;

  hhg_exp_pipe #(
    .FRAC_BITS (FRAC_BITS),
    .ZW        (ZW),
    .SW        ($bits(exp_side_t))
  ) u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (x_v_q),
    .z_i     (x_z_q),
    .side_i  (x_side_q),
    .valid_o (ex_v),
    .e_o     (ex_e),
    .ovf_o   (ex_ovf),
    .side_o  (ex_side)
  );

  // --------------------------------------------------------------------------
  // P1: operands of the second divider
  //   exp-linear: a*2^F/(1-w) for x > 0, a*w/(1-w) for x < 0
  //   sigmoid:    |gain|*2^F/(1+e)
  // --------------------------------------------------------------------------
  logic             p_v_q, p_use_prod_q;
  logic [PAW-1:0]   p_paw_q;
  logic [N2-1:0]    p_alt_q, p_alt_d;
  logic [D2-1:0]    p_den_q, p_den_d;
  div_side_t        p_side_q;

  always_comb begin
    if (mode_q == MODE_SIGMOID) begin
      p_den_d = ONE + D2'(ex_e);
      p_alt_d = N2'({ar, FRAC_BITS'(0)});
    end else begin
      p_den_d = (D2'(ex_e) >= ONE) ? D2'(1) : ONE - D2'(ex_e);
      p_alt_d = N2'({ex_side.a[AT-1:0], FRAC_BITS'(0)});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (adv) begin
      p_v_q <= ex_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_paw_q        <= ex_side.a[AT-1:0] * ex_e[FRAC_BITS:0];
      p_alt_q        <= p_alt_d;
      p_den_q        <= p_den_d;
      p_use_prod_q   <= (mode_q == MODE_EXPLIN) && ex_side.xneg;
      p_side_q.e     <= ex_e;
      p_side_q.ovf   <= ex_ovf;
      p_side_q.a     <= ex_side.a;
      p_side_q.xneg  <= ex_side.xneg;
      p_side_q.azero <= ex_side.a == '0;
      p_side_q.wz    <= ex_e == '0;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 2
  // --------------------------------------------------------------------------
  logic          dv2_v;
  logic [N2-1:0] dv2_q;
  div_side_t     dv2_side;

  hhg_div_pipe #(
    .NW (N2),
    .DW (D2),
    .SW ($bits(div_side_t))
  ) u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (p_v_q),
    .num_i   (p_use_prod_q ? N2'(p_paw_q) : p_alt_q),
    .den_i   (p_den_q),
    .side_i  (p_side_q),
    .valid_o (dv2_v),
    .quot_o  (dv2_q),
    .side_o  (dv2_side)
  );

  // --------------------------------------------------------------------------
  // Q: choose the multiply operand or a direct result
  // --------------------------------------------------------------------------
  logic          q_v_q;
  logic [QW-1:0] q_op_q, q_op_d;
  mul_side_t     q_side_q, q_side_d;

  always_comb begin
    q_op_d        = '0;
    q_side_d.kind = K_ZERO;
    q_side_d.mdir = dv2_q[31:0];
    case (mode_q)
      MODE_EXP: begin
        if (dv2_side.ovf) begin
          q_side_d.kind = (ar != '0) ? K_SAT : K_ZERO;
        end else begin
          q_side_d.kind = K_MUL;
          q_op_d        = QW'(dv2_side.e);
        end
      end
      MODE_EXPLIN: begin
        q_side_d.kind = K_MUL;
        if (dv2_side.azero) begin
          q_op_d = QW'(ONE);
        end else if (dv2_side.wz) begin
          // exp(-|x|) underflowed: linear asymptote, or zero on the other side
          q_op_d = dv2_side.xneg ? '0 : QW'(dv2_side.a);
        end else begin
          q_op_d = QW'(dv2_q);
        end
      end
      MODE_SIGMOID: begin
        q_side_d.kind = dv2_side.ovf ? K_ZERO : K_DIRECT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_v_q <= 1'b0;
    end else if (adv) begin
      q_v_q <= dv2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_op_q   <= q_op_d;
      q_side_q <= q_side_d;
    end
  end

  // --------------------------------------------------------------------------
  // Gain multiply with saturation
  // --------------------------------------------------------------------------
  logic        mul_v, mul_sat;
  logic [31:0] mul_m;
  mul_side_t   mul_side;

  hhg_sat_mul #(
    .FRAC_BITS (FRAC_BITS),
    .SW        ($bits(mul_side_t))
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (q_v_q),
    .ar_i    (ar),
    .neg_i   (rneg),
    .q_i     (q_op_q),
    .side_i  (q_side_q),
    .valid_o (mul_v),
    .m_o     (mul_m),
    .sat_o   (mul_sat),
    .side_o  (mul_side)
  );

  assign last_v = mul_v;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [31:0] sat_val, res_d, rate_q;
  logic [1:0]  status_d, status_q;

  assign sat_val = rneg ? 32'h8000_0000 : 32'h7fff_ffff;

  always_comb begin
    res_d    = '0;
    status_d = ST_OK;
    if (!mode_ok) begin
      res_d = '0;
    end else if (szero) begin
      status_d = ST_ZERO_SCALE;
    end else begin
      case (mul_side.kind)
        K_SAT: begin
          res_d    = sat_val;
          status_d = ST_SATURATED;
        end
        K_DIRECT: res_d = rneg ? 32'd0 - mul_side.mdir : mul_side.mdir;
        K_MUL: begin
          if (mul_sat) begin
            res_d    = sat_val;
            status_d = ST_SATURATED;
          end else begin
            res_d = rneg ? 32'd0 - mul_m : mul_m;
          end
        end
        default: res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= last_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      rate_q   <= res_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rate_value_o = rate_q;
  assign status_o     = status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_SATURATED) |->
      (rate_value_o == 32'h7fff_ffff) || (rate_value_o == 32'h8000_0000))
    else $error("saturated status with non-limit rate");

  a_zero_scale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ZERO_SCALE) |-> (rate_value_o == '0) && szero)
    else $error("zero-scale status with nonzero rate or nonzero scale");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && last_v)
    else $error("input stalled without a blocked result");

  a_unused_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_ok |-> (rate_value_o == '0) && (status_o == ST_OK))
    else $error("unused mode produced a nonzero transaction");

endmodule
